>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

>>> sv/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// types and codes of the local sequence alignment core
// ----------------------------------------------------------------------------
package lsa_pkg;

	// command opcodes
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_TRACE  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_DONE = 2'd0;
	localparam logic [1:0] KIND_CELL = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	// predecessor codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_LEFT = 2'd2;
	localparam logic [1:0] DIR_DIAG = 2'd3;

	// register indexes
	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;

	localparam int RES_SCORE_W = 13;
	localparam int SCORE_SAT   = 8191;
	localparam int POS_W       = 9;
	localparam int PADDR_W     = 4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] symbol;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [RES_SCORE_W-1:0] score;
		logic [POS_W-1:0]       row;
		logic [POS_W-1:0]       col;
		logic [1:0]             direction;
		logic                   path_end;
		logic                   overflow;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_ROWW,
		S_CELL,
		S_DONE,
		S_TR1,
		S_TR2
	} state_t;

endpackage

>>> sv/lsa_stream_if.sv
// ----------------------------------------------------------------------------
// lsa_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface lsa_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> sv/lsa_ram.sv
// ----------------------------------------------------------------------------
// lsa_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

>>> sv/local_sequence_alignment_core.sv
// Loads: one per cycle while cmd.ready is high, no result. Traceback step: result loaded
// in S_TR2 after S_TR1; a none result is registered in the next cycle when no path is active.
// Alignment: S_ROW and S_ROWW per row, S_CELL per column, then S_DONE loads the result
// (S_DONE at once if empty); the score-row read/modify/write settles one cell per cycle.
// A new command is taken in idle when the result register is free or being drained.
// arst_n clears all control state, lengths, best cell and scores; no memory clearing pass.
// ----------------------------------------------------------------------------
// local_sequence_alignment_core
// local alignment with linear gap, row-by-row fill through memories, traceback
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module local_sequence_alignment_core #(
	parameter int MAX_LEN = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	lsa_stream_if.sink                  cmd,
	lsa_stream_if.source                res
);
	localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int SRW = $clog2(31 * MAX_LEN + 1);
	localparam int SW  = (SRW > lsa_pkg::RES_SCORE_W) ? SRW : lsa_pkg::RES_SCORE_W;
	localparam int CW  = SW + 2;
	localparam int PW  = 2 * AW;
	localparam int DW  = LW + 1;

	// configuration registers
	logic [4:0]        match_q;
	logic signed [5:0] mismatch_q;
	logic signed [5:0] gap_q;

	// control and sequence state
	lsa_pkg::state_t state_q, state_d;
	logic [LW-1:0] len_a_q, len_b_q;
	logic          overflow_q, aligned_q;
	logic [LW-1:0] row_q, col_q;
	logic [SW-1:0] diag_q, left_q;
	logic [7:0]    b_sym_q;
	logic [SW-1:0] best_score_q;
	logic [LW-1:0] best_row_q, best_col_q;
	logic [LW-1:0] trace_row_q, trace_col_q;
	logic [SW-1:0] trace_score_q;
	logic          trace_active_q;
	logic [1:0]    tr_p_q;
	logic [LW-1:0] tr_nr_q, tr_nc_q;
	logic [SW-1:0] tr_ns_q;
	logic          res_valid_q;
	lsa_pkg::res_t res_q;

	// memory ports
	logic          a_we, b_we, s_we, p_we;
	logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr, s_waddr, s_raddr;
	logic [PW-1:0] p_waddr, p_raddr;
	logic [7:0]    a_rdata, b_rdata;
	logic [SW-1:0] s_rdata, s_wdata;
	logic [1:0]    p_rdata, p_wdata;

	lsa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_a (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(cmd.data.symbol),
		.raddr(a_raddr), .rdata(a_rdata));
	lsa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_b (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(cmd.data.symbol),
		.raddr(b_raddr), .rdata(b_rdata));
	lsa_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_score_row (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));
	lsa_ram #(.WIDTH(2), .DEPTH(2 ** PW)) u_pred (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));

	// apb access
	logic       cfg_wr;
	logic [1:0] cfg_idx;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		unique case (cfg_idx)
			lsa_pkg::REG_MATCH:    prdata = {27'd0, match_q};
			lsa_pkg::REG_MISMATCH: prdata = 32'(mismatch_q);
			lsa_pkg::REG_GAP:      prdata = 32'(gap_q);
			default:               prdata = 32'd0;
		endcase
	end

	// command handshake
	logic cmd_acc;
	assign cmd.ready = (state_q == lsa_pkg::S_IDLE) && (!res_valid_q || res.ready);
	assign cmd_acc   = cmd.valid && cmd.ready;

	logic          is_load_a, is_load_b, is_start, is_trace;
	logic [LW-1:0] eff_len_a, eff_len_b, new_len_b;
	logic          a_room, b_room;
	assign is_load_a = cmd_acc && (cmd.data.opcode == lsa_pkg::OP_LOAD_A);
	assign is_load_b = cmd_acc && (cmd.data.opcode == lsa_pkg::OP_LOAD_B);
	assign is_start  = is_load_b && cmd.data.last;
	assign is_trace  = cmd_acc && (cmd.data.opcode == lsa_pkg::OP_TRACE);
	assign eff_len_a = aligned_q ? '0 : len_a_q;
	assign eff_len_b = aligned_q ? '0 : len_b_q;
	assign a_room    = eff_len_a < LW'(MAX_LEN);
	assign b_room    = eff_len_b < LW'(MAX_LEN);
	assign new_len_b = b_room ? eff_len_b + LW'(1) : eff_len_b;

	// cell evaluation
	logic signed [6:0]    sub_cell, sub_tr;
	logic signed [CW-1:0] gap_x, up_x, d_x, u_x, l_x, h_x;
	logic [1:0]           p_cell;
	logic [SW-1:0]        h_cell;
	logic [DW-1:0]        dn, db;
	logic                 best_upd;

	assign sub_cell = (a_rdata == b_sym_q) ? 7'(match_q) : 7'(mismatch_q);
	assign gap_x    = CW'(gap_q);
	assign up_x     = (row_q == LW'(1)) ? '0 : signed'({2'b00, s_rdata});
	assign d_x      = signed'({2'b00, diag_q}) + CW'(sub_cell);
	assign u_x      = up_x + gap_x;
	assign l_x      = signed'({2'b00, left_q}) + gap_x;

	always_comb begin
		h_x    = '0;
		p_cell = lsa_pkg::DIR_NONE;
		if (d_x > h_x) begin
			h_x    = d_x;
			p_cell = lsa_pkg::DIR_DIAG;
		end
		if (u_x > h_x) begin
			h_x    = u_x;
			p_cell = lsa_pkg::DIR_UP;
		end
		if (l_x > h_x) begin
			h_x    = l_x;
			p_cell = lsa_pkg::DIR_LEFT;
		end
	end
	assign h_cell = h_x[SW-1:0];

	// first strictly better cell in anti-diagonal order, higher row first
	assign dn = DW'(row_q) + DW'(col_q);
	assign db = DW'(best_row_q) + DW'(best_col_q);
	assign best_upd = (h_cell != '0) && ((h_cell > best_score_q) ||
		((h_cell == best_score_q) && ((dn < db) || ((dn == db) && (row_q > best_row_q)))));

	// traceback step
	logic [LW-1:0]        tr_rm1, tr_cm1, nr, nc;
	logic signed [CW-1:0] ns_x;
	logic [LW-1:0]        nrm1, ncm1;
	assign sub_tr = (a_rdata == b_rdata) ? 7'(match_q) : 7'(mismatch_q);
	assign tr_rm1 = trace_row_q - LW'(1);
	assign tr_cm1 = trace_col_q - LW'(1);

	always_comb begin
		nr   = trace_row_q;
		nc   = trace_col_q;
		ns_x = signed'({2'b00, trace_score_q});
		case (p_rdata)
			lsa_pkg::DIR_DIAG: begin
				nr   = tr_rm1;
				nc   = tr_cm1;
				ns_x = ns_x - CW'(sub_tr);
			end
			lsa_pkg::DIR_UP: begin
				nr   = tr_rm1;
				ns_x = ns_x - gap_x;
			end
			lsa_pkg::DIR_LEFT: begin
				nc   = tr_cm1;
				ns_x = ns_x - gap_x;
			end
			default: begin
				nr = trace_row_q;
			end
		endcase
	end
	assign nrm1 = nr - LW'(1);
	assign ncm1 = nc - LW'(1);

	logic tr_end;
	assign tr_end = (tr_p_q == lsa_pkg::DIR_NONE) || (tr_nr_q == '0) || (tr_nc_q == '0) ||
		(p_rdata == lsa_pkg::DIR_NONE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsa_pkg::S_IDLE: begin
				if (is_start) begin
					state_d = ((new_len_b != '0) && (eff_len_a != '0)) ?
						lsa_pkg::S_ROW : lsa_pkg::S_DONE;
				end else if (is_trace && trace_active_q) begin
					state_d = lsa_pkg::S_TR1;
				end
			end
			lsa_pkg::S_ROW:  state_d = lsa_pkg::S_ROWW;
			lsa_pkg::S_ROWW: state_d = lsa_pkg::S_CELL;
			lsa_pkg::S_CELL: begin
				if (col_q >= len_a_q) begin
					state_d = (row_q < len_b_q) ? lsa_pkg::S_ROW : lsa_pkg::S_DONE;
				end
			end
			lsa_pkg::S_DONE: state_d = lsa_pkg::S_IDLE;
			lsa_pkg::S_TR1:  state_d = lsa_pkg::S_TR2;
			lsa_pkg::S_TR2:  state_d = lsa_pkg::S_IDLE;
			default:         state_d = lsa_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		a_we    = is_load_a && a_room;
		a_waddr = eff_len_a[AW-1:0];
		b_we    = is_load_b && b_room;
		b_waddr = eff_len_b[AW-1:0];
		s_we    = (state_q == lsa_pkg::S_CELL);
		s_waddr = tr_cm1[AW-1:0];
		s_wdata = h_cell;
		p_we    = (state_q == lsa_pkg::S_CELL);
		p_wdata = p_cell;
		p_waddr = {tr_rm1[AW-1:0], tr_cm1[AW-1:0]};
		a_raddr = tr_cm1[AW-1:0];
		b_raddr = tr_rm1[AW-1:0];
		s_raddr = '0;
		p_raddr = {tr_rm1[AW-1:0], tr_cm1[AW-1:0]};
		unique case (state_q)
			lsa_pkg::S_ROW: begin
				b_raddr = AW'(row_q - LW'(1));
			end
			lsa_pkg::S_ROWW: begin
				a_raddr = '0;
			end
			lsa_pkg::S_CELL: begin
				a_raddr = col_q[AW-1:0];
				s_raddr = col_q[AW-1:0];
				s_waddr = AW'(col_q - LW'(1));
				p_waddr = {AW'(row_q - LW'(1)), AW'(col_q - LW'(1))};
			end
			lsa_pkg::S_TR1: begin
				p_raddr = {nrm1[AW-1:0], ncm1[AW-1:0]};
			end
			default: begin
				s_raddr = '0;
			end
		endcase
	end

	// saturated score for the result
	function automatic logic [lsa_pkg::RES_SCORE_W-1:0] sat_score(input logic [SW-1:0] s);
		sat_score = (s > SW'(lsa_pkg::SCORE_SAT)) ? lsa_pkg::RES_SCORE_W'(lsa_pkg::SCORE_SAT)
			: lsa_pkg::RES_SCORE_W'(s);
	endfunction

	// result load
	logic          res_load;
	lsa_pkg::res_t res_d;
	always_comb begin
		res_load       = 1'b0;
		res_d          = '0;
		res_d.overflow = overflow_q;
		if (state_q == lsa_pkg::S_DONE) begin
			res_load    = 1'b1;
			res_d.kind  = lsa_pkg::KIND_DONE;
			res_d.score = sat_score(best_score_q);
			res_d.row   = lsa_pkg::POS_W'(best_row_q);
			res_d.col   = lsa_pkg::POS_W'(best_col_q);
		end else if (state_q == lsa_pkg::S_TR2) begin
			res_load        = 1'b1;
			res_d.kind      = lsa_pkg::KIND_CELL;
			res_d.score     = sat_score(trace_score_q);
			res_d.row       = lsa_pkg::POS_W'(trace_row_q);
			res_d.col       = lsa_pkg::POS_W'(trace_col_q);
			res_d.direction = tr_p_q;
			res_d.path_end  = tr_end;
		end else if (is_trace && !trace_active_q) begin
			res_load   = 1'b1;
			res_d.kind = lsa_pkg::KIND_NONE;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lsa_pkg::S_IDLE;
			match_q        <= 5'd5;
			mismatch_q     <= -6'sd3;
			gap_q          <= -6'sd4;
			len_a_q        <= '0;
			len_b_q        <= '0;
			overflow_q     <= 1'b0;
			aligned_q      <= 1'b0;
			row_q          <= '0;
			col_q          <= '0;
			diag_q         <= '0;
			left_q         <= '0;
			b_sym_q        <= '0;
			best_score_q   <= '0;
			best_row_q     <= '0;
			best_col_q     <= '0;
			trace_row_q    <= '0;
			trace_col_q    <= '0;
			trace_score_q  <= '0;
			trace_active_q <= 1'b0;
			tr_p_q         <= lsa_pkg::DIR_NONE;
			tr_nr_q        <= '0;
			tr_nc_q        <= '0;
			tr_ns_q        <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wr) begin
				case (cfg_idx)
					lsa_pkg::REG_MATCH:    match_q    <= pwdata[4:0];
					lsa_pkg::REG_MISMATCH: mismatch_q <= signed'(pwdata[5:0]);
					lsa_pkg::REG_GAP:      gap_q      <= signed'(pwdata[5:0]);
					default:               match_q    <= match_q;
				endcase
			end

			// symbol loads, a new pair after an alignment
			if (is_load_a || is_load_b) begin
				aligned_q <= 1'b0;
				len_a_q   <= eff_len_a;
				len_b_q   <= eff_len_b;
				if (aligned_q) begin
					trace_active_q <= 1'b0;
				end
				if (is_load_a) begin
					if (a_room) len_a_q <= eff_len_a + LW'(1);
				end else begin
					len_b_q <= new_len_b;
				end
				overflow_q <= (aligned_q ? 1'b0 : overflow_q) ||
					(is_load_a ? !a_room : !b_room);
			end

			if (is_start) begin
				best_score_q <= '0;
				best_row_q   <= '0;
				best_col_q   <= '0;
				row_q        <= LW'(1);
			end

			// fill sweep
			if (state_q == lsa_pkg::S_ROWW) begin
				b_sym_q <= b_rdata;
				col_q   <= LW'(1);
				diag_q  <= '0;
				left_q  <= '0;
			end
			if (state_q == lsa_pkg::S_CELL) begin
				diag_q <= up_x[SW-1:0];
				left_q <= h_cell;
				if (best_upd) begin
					best_score_q <= h_cell;
					best_row_q   <= row_q;
					best_col_q   <= col_q;
				end
				if (col_q < len_a_q) begin
					col_q <= col_q + LW'(1);
				end else begin
					row_q <= row_q + LW'(1);
				end
			end
			if (state_q == lsa_pkg::S_DONE) begin
				aligned_q      <= 1'b1;
				trace_active_q <= (best_score_q != '0);
				trace_row_q    <= best_row_q;
				trace_col_q    <= best_col_q;
				trace_score_q  <= best_score_q;
			end

			// traceback
			if (state_q == lsa_pkg::S_TR1) begin
				tr_p_q  <= p_rdata;
				tr_nr_q <= nr;
				tr_nc_q <= nc;
				tr_ns_q <= ns_x[SW-1:0];
			end
			if (state_q == lsa_pkg::S_TR2) begin
				trace_row_q   <= tr_nr_q;
				trace_col_q   <= tr_nc_q;
				trace_score_q <= tr_ns_q;
				if (tr_end) begin
					trace_active_q <= 1'b0;
				end
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// checks
	`ASSERT_CLK(a_res_slot_free, res_load |-> (!res_valid_q || res.ready), "result overwritten")
	`ASSERT_CLK(a_fill_col_range, (state_q == lsa_pkg::S_CELL) |-> (col_q != '0 && col_q <= len_a_q), "fill column out of range")
	`ASSERT_NEVER(a_trace_origin, trace_active_q && (trace_row_q == '0 || trace_col_q == '0), "active trace at border")
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the local alignment core against an in-bench scoring model: random
// sequence pairs, tracebacks and register settings, with random stalls
// ----------------------------------------------------------------------------
module tb_top;
	localparam int CAP = 256;
	localparam int QUIET_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [lsa_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lsa_stream_if #(.T(lsa_pkg::cmd_t)) cmd_ch ();
	lsa_stream_if #(.T(lsa_pkg::res_t)) res_ch ();

	local_sequence_alignment_core DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd(cmd_ch.sink), .res(res_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int unsigned m_match;
	int m_mismatch, m_gap;
	byte unsigned a_sym[CAP], b_sym[CAP];
	int n_a, n_b;
	int row_score[CAP+1];
	logic [1:0] pred_dir[CAP*CAP];
	int top_score, top_row, top_col, walk_row, walk_col, walk_score;
	bit walk_on, dropped, pair_done;

	lsa_pkg::cmd_t pending_cmds[$];
	lsa_pkg::res_t expected_results[$];
	int fail_count = 0;
	int quiet = 0;

	function automatic logic [12:0] clip13(int s);
		if (s < 0) return 13'd0;
		if (s > lsa_pkg::SCORE_SAT) return 13'(lsa_pkg::SCORE_SAT);
		return 13'(s);
	endfunction

	function automatic int pair_score(int r, int c);
		return (a_sym[c-1] == b_sym[r-1]) ? int'(m_match) : m_mismatch;
	endfunction

	function automatic logic [1:0] dir_at(int r, int c);
		if (r == 0 || c == 0) return lsa_pkg::DIR_NONE;
		return pred_dir[(r-1)*CAP + c-1];
	endfunction

	// full score matrix fill, best cell by anti-diagonal then higher row
	function automatic void fill_matrix();
		int diag_prev, left, d, u, l, h, dn, db;
		logic [1:0] p;
		for (int j = 0; j <= CAP; j++) row_score[j] = 0;
		top_score = 0; top_row = 0; top_col = 0;
		for (int i = 1; i <= n_b; i++) begin
			diag_prev = 0; left = 0;
			for (int j = 1; j <= n_a; j++) begin
				d = diag_prev + pair_score(i, j);
				u = row_score[j] + m_gap;
				l = left + m_gap;
				h = 0; p = lsa_pkg::DIR_NONE;
				if (d > h) begin h = d; p = lsa_pkg::DIR_DIAG; end
				if (u > h) begin h = u; p = lsa_pkg::DIR_UP; end
				if (l > h) begin h = l; p = lsa_pkg::DIR_LEFT; end
				diag_prev = row_score[j];
				row_score[j] = h;
				left = h;
				pred_dir[(i-1)*CAP + j-1] = p;
				dn = i + j; db = top_row + top_col;
				if (h > 0 && (h > top_score ||
						(h == top_score && (dn < db || (dn == db && i > top_row))))) begin
					top_score = h; top_row = i; top_col = j;
				end
			end
		end
	endfunction

	// expected result of one command
	function automatic void predict_command(lsa_pkg::cmd_t c);
		lsa_pkg::res_t r;
		logic [1:0] p;
		int nr, nc;
		r = '0;
		if (c.opcode == lsa_pkg::OP_LOAD_A || c.opcode == lsa_pkg::OP_LOAD_B) begin
			if (pair_done) begin
				pair_done = 0; n_a = 0; n_b = 0; dropped = 0; walk_on = 0;
			end
			if (c.opcode == lsa_pkg::OP_LOAD_A) begin
				if (n_a < CAP) a_sym[n_a++] = c.symbol; else dropped = 1;
				return;
			end
			if (n_b < CAP) b_sym[n_b++] = c.symbol; else dropped = 1;
			if (!c.last) return;
			fill_matrix();
			pair_done = 1;
			walk_on = top_score > 0;
			walk_row = top_row; walk_col = top_col; walk_score = top_score;
			r.kind = lsa_pkg::KIND_DONE; r.score = clip13(top_score);
			r.row = 9'(top_row); r.col = 9'(top_col); r.overflow = dropped;
			expected_results.push_back(r);
			return;
		end
		if (c.opcode != lsa_pkg::OP_TRACE) return;
		r.overflow = dropped;
		if (!walk_on) begin
			r.kind = lsa_pkg::KIND_NONE;
			expected_results.push_back(r);
			return;
		end
		p = dir_at(walk_row, walk_col);
		nr = walk_row; nc = walk_col;
		r.kind = lsa_pkg::KIND_CELL; r.score = clip13(walk_score);
		r.row = 9'(walk_row); r.col = 9'(walk_col); r.direction = p;
		if (p == lsa_pkg::DIR_DIAG) begin
			walk_score -= pair_score(walk_row, walk_col); nr--; nc--;
		end else if (p == lsa_pkg::DIR_UP) begin
			walk_score -= m_gap; nr--;
		end else if (p == lsa_pkg::DIR_LEFT) begin
			walk_score -= m_gap; nc--;
		end
		if (p == lsa_pkg::DIR_NONE || dir_at(nr, nc) == lsa_pkg::DIR_NONE) begin
			r.path_end = 1'b1; walk_on = 0;
		end
		walk_row = nr; walk_col = nc;
		expected_results.push_back(r);
	endfunction

	task automatic report_mismatch(string what, lsa_pkg::res_t got, lsa_pkg::res_t want);
		$display("mismatch %s: got %p want %p at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// command driver, idle cycles drawn per transaction
	int send_gap = 0;
	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			predict_command(cmd_ch.data);
		end
		if (!cmd_ch.valid || cmd_ch.ready) begin
			if (send_gap > 0) begin
				cmd_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_cmds.size() > 0) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.data <= pending_cmds.pop_front();
				send_gap <= $urandom_range(0, 10);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor with random backpressure
	int hold = 0;
	int res_wait = 0;
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected", res_ch.data, '0);
			end else begin
				lsa_pkg::res_t want;
				want = expected_results.pop_front();
				if (res_ch.data.kind != want.kind) report_mismatch("kind", res_ch.data, want);
				if (res_ch.data.score != want.score) report_mismatch("score", res_ch.data, want);
				if (res_ch.data.row != want.row) report_mismatch("row", res_ch.data, want);
				if (res_ch.data.col != want.col) report_mismatch("col", res_ch.data, want);
				if (res_ch.data.direction != want.direction)
					report_mismatch("direction", res_ch.data, want);
				if (res_ch.data.path_end != want.path_end)
					report_mismatch("path_end", res_ch.data, want);
				if (res_ch.data.overflow != want.overflow)
					report_mismatch("overflow", res_ch.data, want);
			end
			res_wait = $urandom_range(0, 10);
			res_ch.ready <= (res_wait == 0);
			hold <= (res_wait == 0) ? 0 : res_wait - 1;
		end else if (hold > 0) begin
			hold <= hold - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// idle watchdog
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
	end

	task automatic apb_write(logic [1:0] idx, int value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= lsa_pkg::PADDR_W'(4 * idx); pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == lsa_pkg::REG_MATCH) m_match = value & 31;
		else if (idx == lsa_pkg::REG_MISMATCH) m_mismatch = value;
		else m_gap = value;
	endtask

	task automatic set_scores(int mt, int mm, int gp);
		apb_write(lsa_pkg::REG_MATCH, mt);
		apb_write(lsa_pkg::REG_MISMATCH, mm);
		apb_write(lsa_pkg::REG_GAP, gp);
	endtask

	function automatic void push_cmd(logic [1:0] op, logic [7:0] sym, logic lst);
		lsa_pkg::cmd_t c;
		c.opcode = op; c.symbol = sym; c.last = lst;
		pending_cmds.push_back(c);
	endfunction

	// a pair drawn from symbols 0 to alpha so matches can happen, then a traceback walk
	function automatic int queue_pair(int la, int lb, int alpha, int walks);
		for (int i = 0; i < la; i++)
			push_cmd(lsa_pkg::OP_LOAD_A, 8'($urandom_range(0, alpha)), 1'($urandom));
		for (int i = 0; i < lb; i++)
			push_cmd(lsa_pkg::OP_LOAD_B, 8'($urandom_range(0, alpha)), i == lb - 1);
		for (int i = 0; i < walks; i++)
			push_cmd(lsa_pkg::OP_TRACE, 8'($urandom), 1'($urandom));
		return la + lb + walks;
	endfunction

	// drain: wait until queues are empty, then out-wait a fill with no result
	task automatic drain();
		while (pending_cmds.size() > 0 || cmd_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int sent;
		int mode;
		m_match = 5; m_mismatch = -3; m_gap = -4;
		n_a = 0; n_b = 0; dropped = 0; pair_done = 0; walk_on = 0;
		top_score = 0; top_row = 0; top_col = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: trace before alignment, ignored opcode, empty a, extremes
		push_cmd(lsa_pkg::OP_TRACE, 8'hFF, 1'b1);
		push_cmd(2'd3, 8'hA5, 1'b1);
		push_cmd(lsa_pkg::OP_LOAD_B, 8'h00, 1'b1);
		push_cmd(lsa_pkg::OP_TRACE, 8'h00, 1'b0);
		push_cmd(lsa_pkg::OP_LOAD_A, 8'hFF, 1'b0);
		push_cmd(lsa_pkg::OP_LOAD_A, 8'h00, 1'b1);
		push_cmd(lsa_pkg::OP_LOAD_A, 8'h5A, 1'b0);
		push_cmd(lsa_pkg::OP_LOAD_B, 8'h00, 1'b0);
		push_cmd(lsa_pkg::OP_LOAD_B, 8'hFF, 1'b0);
		push_cmd(lsa_pkg::OP_LOAD_B, 8'h5A, 1'b1);
		for (int i = 0; i < 5; i++) push_cmd(lsa_pkg::OP_TRACE, 8'h00, 1'b0);
		// no match at all: zero best score
		push_cmd(lsa_pkg::OP_LOAD_A, 8'h01, 1'b0);
		push_cmd(lsa_pkg::OP_LOAD_B, 8'h02, 1'b1);
		push_cmd(lsa_pkg::OP_TRACE, 8'h00, 1'b0);
		drain();

		// capacity: overflow on both sequences, dropped last b still aligns
		set_scores(31, 0, 0);
		for (int i = 0; i < CAP + 2; i++)
			push_cmd(lsa_pkg::OP_LOAD_A, 8'($urandom_range(0, 1)), 1'b0);
		for (int i = 0; i < CAP + 1; i++)
			push_cmd(lsa_pkg::OP_LOAD_B, 8'($urandom_range(0, 1)), i == CAP);
		push_cmd(lsa_pkg::OP_TRACE, 8'h00, 1'b0);
		push_cmd(lsa_pkg::OP_TRACE, 8'h00, 1'b0);
		drain();
		set_scores(0, -31, -31);
		sent = queue_pair(3, 3, 1, 2);
		drain();

		// random pairs under rotating score settings, topping up to at least 1050 commands in all
		sent = 0;
		mode = 0;
		while (sent < 1050) begin
			case (mode % 4)
				0: set_scores(5, -3, -4);
				1: set_scores(31, -31, -31);
				2: set_scores($urandom_range(0, 31), -$urandom_range(0, 31), -$urandom_range(0, 31));
				default: set_scores(31, 0, 0);
			endcase
			mode++;
			for (int k = 0; k < 6; k++) begin
				if ($urandom_range(0, 9) == 0)
					push_cmd(2'($urandom), 8'($urandom), 1'b0);
				sent += queue_pair($urandom_range(0, 12), $urandom_range(1, 12),
					$urandom_range(0, 9) == 0 ? 255 : $urandom_range(1, 3),
					$urandom_range(0, 14));
			end
			drain();
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
